// File: rtl/sfm_pkg.sv
package sfm_pkg;

  // Default width of the run counters and histogram bins
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned HDR_W   = 4;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned VERD_W  = 2;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // Verdict codes
  localparam logic [VERD_W-1:0] VERDICT_PASS       = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_HDR_WARN   = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_STUCK_LOW  = 2'd2;
  localparam logic [VERD_W-1:0] VERDICT_STUCK_HIGH = 2'd3;

  // Register word index (paddr[2])
  localparam logic REG_EXPECTED_HEADER = 1'b0;

  localparam logic [WORD_W-1:0] WORD_ZERO = 16'h0000;
  localparam logic [WORD_W-1:0] WORD_ONES = 16'hFFFF;

endpackage

// File: rtl/sfm_if.sv
interface sfm_frame_if;
  logic        valid;
  logic        ready;
  logic [15:0] rx_word;
  logic        last_frame;

  modport source (output valid, rx_word, last_frame, input ready);
  modport sink   (input valid, rx_word, last_frame, output ready);
endinterface

interface sfm_report_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [15:0] header_ok;
  logic [15:0] header_bad;
  logic [15:0] zero_frames;
  logic [15:0] ones_frames;
  logic [15:0] repeat_frames;
  logic [7:0]  min_code;
  logic [7:0]  max_code;
  logic [3:0]  top_header;
  logic [15:0] top_header_count;
  logic [15:0] min_word;
  logic [15:0] max_word;

  modport source (output valid, verdict, header_ok, header_bad, zero_frames, ones_frames,
                  repeat_frames, min_code, max_code, top_header, top_header_count,
                  min_word, max_word,
                  input ready);
  modport sink   (input valid, verdict, header_ok, header_bad, zero_frames, ones_frames,
                  repeat_frames, min_code, max_code, top_header, top_header_count,
                  min_word, max_word,
                  output ready);
endinterface

// File: rtl/spi_adc_frame_format_monitor_unit.sv
// Channel    Dir  Handshake       Word
// ---------  ---  --------------  ------------------------------------------------
// frame_i    in   valid/ready     rx_word[15:0], last_frame
// report_o   out  valid/ready     verdict, header counts, frame counts, min/max
// apb        in   psel/penable    expected_header at byte address 0
//
// A frame that is not last is accepted, then takes six steps of the shared
// saturating incrementer (repeat, total, header bin, match/mismatch, zero, ones).
// A last frame adds a histogram scan on the shared comparator and a report
// step. The report step waits while a previous report is still held; new frames
// are accepted while a report waits on report_o.
// rst_ni is asynchronous; all run state is flops and clears at once, no sweep.
module spi_adc_frame_format_monitor_unit #(
  parameter int unsigned COUNT_BITS = sfm_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sfm_frame_if.sink                  frame_i,
  sfm_report_if.source               report_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfm_pkg::APB_AW-1:0] paddr,
  input  logic [sfm_pkg::APB_DW-1:0] pwdata,
  output logic [sfm_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import sfm_pkg::*;

  localparam int unsigned CW = COUNT_BITS;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CNT  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_RPT  = 2'd3;

  // Incrementer steps
  localparam logic [2:0] STEP_REPEAT = 3'd0;
  localparam logic [2:0] STEP_TOTAL  = 3'd1;
  localparam logic [2:0] STEP_BIN    = 3'd2;
  localparam logic [2:0] STEP_MATCH  = 3'd3;
  localparam logic [2:0] STEP_ZERO   = 3'd4;
  localparam logic [2:0] STEP_ONES   = 3'd5;

  function automatic logic [CNT_W-1:0] clamp16(input logic [31:0] c);
    return (c > 32'h0000_FFFF) ? 16'hFFFF : c[CNT_W-1:0];
  endfunction

  logic [1:0]        state_q, state_d;
  logic [3:0]        idx_q, idx_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic              last_q, last_d;
  logic [HDR_W-1:0]  exp_q, exp_d;

  logic [CW-1:0]     hist_q [16];
  logic [CW-1:0]     hist_d [16];
  logic [CW-1:0]     total_q, total_d;
  logic [CW-1:0]     match_q, match_d;
  logic [CW-1:0]     mismatch_q, mismatch_d;
  logic [CW-1:0]     zero_q, zero_d;
  logic [CW-1:0]     ones_q, ones_d;
  logic [CW-1:0]     repeat_q, repeat_d;
  logic [WORD_W-1:0] prev_q, prev_d;
  logic              seen_q, seen_d;
  logic [CODE_W-1:0] code_lo_q, code_lo_d;
  logic [CODE_W-1:0] code_hi_q, code_hi_d;
  logic [WORD_W-1:0] word_lo_q, word_lo_d;
  logic [WORD_W-1:0] word_hi_q, word_hi_d;
  logic [HDR_W-1:0]  best_q, best_d;
  logic [CW-1:0]     best_cnt_q, best_cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [VERD_W-1:0] o_verdict_q, o_verdict_d;
  logic [CNT_W-1:0]  o_ok_q, o_ok_d;
  logic [CNT_W-1:0]  o_bad_q, o_bad_d;
  logic [CNT_W-1:0]  o_zero_q, o_zero_d;
  logic [CNT_W-1:0]  o_ones_q, o_ones_d;
  logic [CNT_W-1:0]  o_rep_q, o_rep_d;
  logic [CODE_W-1:0] o_cmin_q, o_cmin_d;
  logic [CODE_W-1:0] o_cmax_q, o_cmax_d;
  logic [HDR_W-1:0]  o_top_q, o_top_d;
  logic [CNT_W-1:0]  o_topcnt_q, o_topcnt_d;
  logic [WORD_W-1:0] o_wmin_q, o_wmin_d;
  logic [WORD_W-1:0] o_wmax_q, o_wmax_d;

  logic              in_acc, out_acc, cfg_wr;
  logic [HDR_W-1:0]  hdr;
  logic [CODE_W-1:0] code;
  logic [2:0]        step;
  logic [CW-1:0]     inc_op, inc_res;
  logic              inc_en;
  logic              hdr_match;

  assign hdr       = word_q[15:12];
  assign code      = word_q[11:4];
  assign step      = idx_q[2:0];
  assign hdr_match = (hdr == exp_q);

  assign frame_i.ready = (state_q == ST_IDLE);
  assign in_acc        = frame_i.valid && frame_i.ready;
  assign out_acc       = report_o.valid && report_o.ready;

  // APB: single register, low address bits are byte lanes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_EXPECTED_HEADER);
  assign prdata = (paddr[2] == REG_EXPECTED_HEADER) ? {{(APB_DW-HDR_W){1'b0}}, exp_q} : '0;

  // Shared saturating incrementer: operand and enable per step
  always_comb begin
    inc_op = '0;
    inc_en = 1'b0;
    unique case (step)
      STEP_REPEAT: begin
        inc_op = repeat_q;
        inc_en = seen_q && (word_q == prev_q);
      end
      STEP_TOTAL: begin
        inc_op = total_q;
        inc_en = 1'b1;
      end
      STEP_BIN: begin
        inc_op = hist_q[hdr];
        inc_en = 1'b1;
      end
      STEP_MATCH: begin
        inc_op = hdr_match ? match_q : mismatch_q;
        inc_en = 1'b1;
      end
      STEP_ZERO: begin
        inc_op = zero_q;
        inc_en = (word_q == WORD_ZERO);
      end
      STEP_ONES: begin
        inc_op = ones_q;
        inc_en = (word_q == WORD_ONES);
      end
      default: begin
        inc_op = '0;
        inc_en = 1'b0;
      end
    endcase
    inc_res = (inc_op == CMAX) ? inc_op : inc_op + CW'(1);
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    word_d     = word_q;
    last_d     = last_q;
    exp_d      = exp_q;
    hist_d     = hist_q;
    total_d    = total_q;
    match_d    = match_q;
    mismatch_d = mismatch_q;
    zero_d     = zero_q;
    ones_d     = ones_q;
    repeat_d   = repeat_q;
    prev_d     = prev_q;
    seen_d     = seen_q;
    code_lo_d  = code_lo_q;
    code_hi_d  = code_hi_q;
    word_lo_d  = word_lo_q;
    word_hi_d  = word_hi_q;
    best_d     = best_q;
    best_cnt_d = best_cnt_q;

    out_valid_d = out_valid_q && !out_acc;
    o_verdict_d = o_verdict_q;
    o_ok_d      = o_ok_q;
    o_bad_d     = o_bad_q;
    o_zero_d    = o_zero_q;
    o_ones_d    = o_ones_q;
    o_rep_d     = o_rep_q;
    o_cmin_d    = o_cmin_q;
    o_cmax_d    = o_cmax_q;
    o_top_d     = o_top_q;
    o_topcnt_d  = o_topcnt_q;
    o_wmin_d    = o_wmin_q;
    o_wmax_d    = o_wmax_q;

    if (cfg_wr) begin
      exp_d = pwdata[HDR_W-1:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          word_d  = frame_i.rx_word;
          last_d  = frame_i.last_frame;
          idx_d   = '0;
          state_d = ST_CNT;
        end
      end

      ST_CNT: begin
        if (inc_en) begin
          unique case (step)
            STEP_REPEAT: repeat_d = inc_res;
            STEP_TOTAL:  total_d  = inc_res;
            STEP_BIN:    hist_d[hdr] = inc_res;
            STEP_MATCH: begin
              if (hdr_match) match_d = inc_res;
              else           mismatch_d = inc_res;
            end
            STEP_ZERO:   zero_d = inc_res;
            STEP_ONES:   ones_d = inc_res;
            default:     ;
          endcase
        end
        idx_d = idx_q + 4'd1;
        if (step == STEP_ONES) begin
          // repeat check is done, frame becomes the previous one
          prev_d = word_q;
          seen_d = 1'b1;
          if (code < code_lo_q)   code_lo_d = code;
          if (code > code_hi_q)   code_hi_d = code;
          if (word_q < word_lo_q) word_lo_d = word_q;
          if (word_q > word_hi_q) word_hi_d = word_q;
          if (last_q) begin
            best_d     = '0;
            best_cnt_d = hist_q[0];
            idx_d      = 4'd1;
            state_d    = ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_SCAN: begin
        // strict compare keeps the lowest index on ties
        if (hist_q[idx_q] > best_cnt_q) begin
          best_d     = idx_q;
          best_cnt_d = hist_q[idx_q];
        end
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd15) begin
          state_d = ST_RPT;
        end
      end

      ST_RPT: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          if (zero_q == total_q)      o_verdict_d = VERDICT_STUCK_LOW;
          else if (ones_q == total_q) o_verdict_d = VERDICT_STUCK_HIGH;
          else if (mismatch_q != '0)  o_verdict_d = VERDICT_HDR_WARN;
          else                        o_verdict_d = VERDICT_PASS;
          o_ok_d     = clamp16(32'(match_q));
          o_bad_d    = clamp16(32'(mismatch_q));
          o_zero_d   = clamp16(32'(zero_q));
          o_ones_d   = clamp16(32'(ones_q));
          o_rep_d    = clamp16(32'(repeat_q));
          o_cmin_d   = code_lo_q;
          o_cmax_d   = code_hi_q;
          o_top_d    = best_q;
          o_topcnt_d = clamp16(32'(best_cnt_q));
          o_wmin_d   = word_lo_q;
          o_wmax_d   = word_hi_q;
          // new run
          for (int i = 0; i < 16; i++) hist_d[i] = '0;
          total_d    = '0;
          match_d    = '0;
          mismatch_d = '0;
          zero_d     = '0;
          ones_d     = '0;
          repeat_d   = '0;
          prev_d     = WORD_ONES;
          seen_d     = 1'b0;
          code_lo_d  = '1;
          code_hi_d  = '0;
          word_lo_d  = WORD_ONES;
          word_hi_d  = '0;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      exp_q       <= '0;
      for (int i = 0; i < 16; i++) hist_q[i] <= '0;
      total_q     <= '0;
      match_q     <= '0;
      mismatch_q  <= '0;
      zero_q      <= '0;
      ones_q      <= '0;
      repeat_q    <= '0;
      prev_q      <= WORD_ONES;
      seen_q      <= 1'b0;
      code_lo_q   <= '1;
      code_hi_q   <= '0;
      word_lo_q   <= WORD_ONES;
      word_hi_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      exp_q       <= exp_d;
      hist_q      <= hist_d;
      total_q     <= total_d;
      match_q     <= match_d;
      mismatch_q  <= mismatch_d;
      zero_q      <= zero_d;
      ones_q      <= ones_d;
      repeat_q    <= repeat_d;
      prev_q      <= prev_d;
      seen_q      <= seen_d;
      code_lo_q   <= code_lo_d;
      code_hi_q   <= code_hi_d;
      word_lo_q   <= word_lo_d;
      word_hi_q   <= word_hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    word_q      <= word_d;
    last_q      <= last_d;
    best_q      <= best_d;
    best_cnt_q  <= best_cnt_d;
    o_verdict_q <= o_verdict_d;
    o_ok_q      <= o_ok_d;
    o_bad_q     <= o_bad_d;
    o_zero_q    <= o_zero_d;
    o_ones_q    <= o_ones_d;
    o_rep_q     <= o_rep_d;
    o_cmin_q    <= o_cmin_d;
    o_cmax_q    <= o_cmax_d;
    o_top_q     <= o_top_d;
    o_topcnt_q  <= o_topcnt_d;
    o_wmin_q    <= o_wmin_d;
    o_wmax_q    <= o_wmax_d;
  end

  assign report_o.valid            = out_valid_q;
  assign report_o.verdict          = o_verdict_q;
  assign report_o.header_ok        = o_ok_q;
  assign report_o.header_bad       = o_bad_q;
  assign report_o.zero_frames      = o_zero_q;
  assign report_o.ones_frames      = o_ones_q;
  assign report_o.repeat_frames    = o_rep_q;
  assign report_o.min_code         = o_cmin_q;
  assign report_o.max_code         = o_cmax_q;
  assign report_o.top_header       = o_top_q;
  assign report_o.top_header_count = o_topcnt_q;
  assign report_o.min_word         = o_wmin_q;
  assign report_o.max_word         = o_wmax_q;

endmodule

// File: rtl/sfm_checker.sv
module sfm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  verdict_i,
  input logic [15:0] header_bad_i,
  input logic [15:0] zero_frames_i,
  input logic [15:0] ones_frames_i,
  input logic [15:0] min_word_i,
  input logic [15:0] max_word_i
);
  import sfm_pkg::*;

  // a held report keeps its verdict
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(verdict_i))
    else $error("report dropped or changed while stalled");

  // one frame at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("frame accepted while previous frame in progress");

  // saturated counts can tie with other frames present, so only require
  // that at least one all-zero frame was seen
  a_stuck_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (verdict_i == VERDICT_STUCK_LOW) |-> (min_word_i == WORD_ZERO)
      && (zero_frames_i != 16'd0))
    else $error("stuck-low verdict without an all-zero frame");

  a_stuck_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (verdict_i == VERDICT_STUCK_HIGH) |-> (max_word_i == WORD_ONES)
      && (ones_frames_i != 16'd0))
    else $error("stuck-high verdict without an all-one frame");

  a_pass_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (verdict_i == VERDICT_PASS || verdict_i == VERDICT_HDR_WARN)
      |-> (min_word_i <= max_word_i) && ((verdict_i == VERDICT_HDR_WARN) ||
      (header_bad_i == 16'd0)))
    else $error("report inconsistent with verdict");

endmodule

bind spi_adc_frame_format_monitor_unit sfm_checker u_sfm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (frame_i.valid),
  .in_ready_i   (frame_i.ready),
  .out_valid_i  (report_o.valid),
  .out_ready_i  (report_o.ready),
  .verdict_i    (report_o.verdict),
  .header_bad_i (report_o.header_bad),
  .zero_frames_i(report_o.zero_frames),
  .ones_frames_i(report_o.ones_frames),
  .min_word_i   (report_o.min_word),
  .max_word_i   (report_o.max_word)
);
